@@ src/oais_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oais_pkg
// Shared sizes, codes and types of the ordered word list with insert,
// update and first-match search.
// ---------------------------------------------------------------------------
package oais_pkg;

  // Storage size and derived widths
  localparam int DEPTH     = 256;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int PAD       = 1 << IDX_W;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Request and response field widths
  localparam int OP_W      = 2;
  localparam int POS_W     = 9;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 3;

  // Width for position against count compares
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Search wait: covers the compare row and every tree level
  localparam int WAIT_LAST = IDX_W + 1;
  localparam int WAIT_W    = $clog2(WAIT_LAST + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SEARCH = 2'd2
  } oais_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_BADPOS   = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_NOTFOUND = 3'd4
  } oais_status_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } oais_state_e;

  // Per-cell write control
  typedef struct packed {
    logic load;   // cell takes a new word this cycle
    logic shift;  // new word comes from the lower neighbour, else from the request
  } oais_cell_ctrl_t;

endpackage

@@ src/oais_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oais_req_if
// Request channel: operation, position and word with valid/ready.
// ---------------------------------------------------------------------------
interface oais_req_if;
  import oais_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

@@ src/oais_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oais_rsp_if
// Response channel: status, found position and count with valid/ready.
// ---------------------------------------------------------------------------
interface oais_rsp_if;
  import oais_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     found_position;
  logic [POS_W-1:0]     count;

  modport source (output valid, output status, output found_position, output count,
                  input ready);
  modport sink   (input valid, input status, input found_position, input count,
                  output ready);
endinterface

@@ src/oais_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oais_cell
// One list entry: holds a word, takes either the request word or its lower
// neighbour's word, and registers a match against the search key.
// ---------------------------------------------------------------------------
module oais_cell import oais_pkg::*; (
  input  logic                     clk_i,
  input  oais_cell_ctrl_t          ctrl_i,
  input  logic signed [WORD_W-1:0] shift_word_i,
  input  logic signed [WORD_W-1:0] new_word_i,
  input  logic signed [WORD_W-1:0] key_i,
  input  logic                     active_i,
  output logic signed [WORD_W-1:0] word_o,
  output logic                     hit_o
);

  logic signed [WORD_W-1:0] word_q;
  logic                     hit_q;

  // Entry storage (undefined until written)
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      word_q <= ctrl_i.shift ? shift_word_i : new_word_i;
    end
  end

  // Match flag, only for occupied entries
  always_ff @(posedge clk_i) begin
    hit_q <= active_i && (word_q == key_i);
  end

  assign word_o = word_q;
  assign hit_o  = hit_q;

endmodule

@@ src/oais_prio_tree.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oais_prio_tree
// Registered binary tree that finds the lowest-index set match flag.
// One register level per tree level, from the leaf pairs up to the root.
// ---------------------------------------------------------------------------
module oais_prio_tree import oais_pkg::*; (
  input  logic             clk_i,
  input  logic [DEPTH-1:0] hit_i,
  output logic             hit_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [PAD-1:0]   leaf_hit;
  logic             node_hit_q [1:PAD-1];
  logic [IDX_W-1:0] node_idx_q [1:PAD-1];

  // Pad leaves up to a power of two
  always_comb begin
    leaf_hit              = '0;
    leaf_hit[DEPTH-1:0]   = hit_i;
  end

  // Node k merges children 2k and 2k+1, lower child wins
  for (genvar k = 1; k < PAD; k++) begin : g_node
    if (2 * k >= PAD) begin : g_leaf
      localparam int L = 2 * k - PAD;
      always_ff @(posedge clk_i) begin
        node_hit_q[k] <= leaf_hit[L] | leaf_hit[L+1];
        node_idx_q[k] <= leaf_hit[L] ? IDX_W'(L) : IDX_W'(L + 1);
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        node_hit_q[k] <= node_hit_q[2*k] | node_hit_q[2*k+1];
        node_idx_q[k] <= node_hit_q[2*k] ? node_idx_q[2*k] : node_idx_q[2*k+1];
      end
    end
  end

  assign hit_o = node_hit_q[1];
  assign idx_o = node_idx_q[1];

endmodule

@@ src/ordered_array_insert_update_search_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_array_insert_update_search_core
// Positional list of signed 32-bit words with insert, update and search.
// ---------------------------------------------------------------------------
// Holds up to DEPTH words in a row of cells plus a fill count; it is empty
// after reset. An insert at a 1-based position moves that entry and all
// later ones up one cell at once; an update rewrites one cell. Both load
// the response register straight from the accepted request. A search
// registers the key, compares every cell with it at once, then a
// registered first-match tree finds the lowest matching position. One
// request is in work at a time; a new request is taken while the previous
// response still waits in the output register, as long as that response
// is being taken in the same cycle. Every response carries the count after
// the request; the found position is non-zero only for a successful
// search.
// ---------------------------------------------------------------------------
module ordered_array_insert_update_search_core import oais_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  oais_req_if.sink   req_i,
  oais_rsp_if.source rsp_o
);

  oais_state_e              state_q, state_d;
  logic [WAIT_W-1:0]        wait_q, wait_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [WORD_W-1:0] key_q;

  logic                     rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]      rsp_status_q, rsp_status_d;
  logic [POS_W-1:0]         rsp_found_q, rsp_found_d;
  logic [POS_W-1:0]         rsp_count_q, rsp_count_d;
  logic                     rsp_load;

  logic                     slot_free;
  logic                     accept;
  logic                     ins_go, upd_go;
  logic [CMP_W-1:0]         pos_x, cnt_x;
  oais_status_e             req_status;

  logic signed [WORD_W-1:0] words [DEPTH];
  logic [DEPTH-1:0]         hits;
  logic                     root_hit;
  logic [IDX_W-1:0]         root_idx;

  // Handshake
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_x = CMP_W'(req_i.position);
  assign cnt_x = CMP_W'(cnt_q);

  // Request checks for insert and update
  always_comb begin
    ins_go     = 1'b0;
    upd_go     = 1'b0;
    req_status = STS_BADPOS;
    unique case (oais_op_e'(req_i.operation))
      OP_INSERT: begin
        if (cnt_q == CNT_W'(DEPTH)) begin
          req_status = STS_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          req_status = STS_BADPOS;
        end else begin
          req_status = STS_OK;
          ins_go     = accept;
        end
      end
      OP_UPDATE: begin
        if (cnt_q == '0) begin
          req_status = STS_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          req_status = STS_BADPOS;
        end else begin
          req_status = STS_OK;
          upd_go     = accept;
        end
      end
      OP_SEARCH: req_status = STS_NOTFOUND;
      default:   req_status = STS_BADPOS;
    endcase
  end

  // Sequencer: next state and response load
  always_comb begin
    state_d      = state_q;
    wait_d       = wait_q;
    cnt_d        = cnt_q;
    rsp_load     = 1'b0;
    rsp_status_d = rsp_status_q;
    rsp_found_d  = rsp_found_q;
    rsp_count_d  = rsp_count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (oais_op_e'(req_i.operation) == OP_SEARCH) begin
            state_d = ST_SEARCH;
            wait_d  = '0;
          end else begin
            if (ins_go) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
            rsp_load     = 1'b1;
            rsp_status_d = req_status;
            rsp_found_d  = '0;
            rsp_count_d  = POS_W'(ins_go ? cnt_q + CNT_W'(1) : cnt_q);
          end
        end
      end
      ST_SEARCH: begin
        if (wait_q != WAIT_W'(WAIT_LAST)) begin
          wait_d = wait_q + WAIT_W'(1);
        end else if (slot_free) begin
          state_d      = ST_IDLE;
          rsp_load     = 1'b1;
          rsp_status_d = root_hit ? STS_OK : STS_NOTFOUND;
          rsp_found_d  = root_hit ? POS_W'(CMP_W'(root_idx) + CMP_W'(1)) : '0;
          rsp_count_d  = POS_W'(cnt_q);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Response payload and search key
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= rsp_status_d;
      rsp_found_q  <= rsp_found_d;
      rsp_count_q  <= rsp_count_d;
    end
    if (accept) begin
      key_q <= req_i.value;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_position = rsp_found_q;
  assign rsp_o.count          = rsp_count_q;

  // Cell row: entry i sits at 1-based position i+1
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    oais_cell_ctrl_t          ctrl;
    logic signed [WORD_W-1:0] lower_word;

    assign ctrl.load  = (ins_go && CMP_W'(i + 1) >= pos_x)
                     || (upd_go && CMP_W'(i + 1) == pos_x);
    assign ctrl.shift = ins_go && CMP_W'(i + 1) > pos_x;

    if (i == 0) begin : g_first
      assign lower_word = req_i.value;
    end else begin : g_rest
      assign lower_word = words[i-1];
    end

    oais_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .shift_word_i (lower_word),
      .new_word_i   (req_i.value),
      .key_i        (key_q),
      .active_i     (CMP_W'(i) < cnt_x),
      .word_o       (words[i]),
      .hit_o        (hits[i])
    );
  end

  // First-match search over the row
  oais_prio_tree u_tree (
    .clk_i (clk_i),
    .hit_i (hits),
    .hit_o (root_hit),
    .idx_o (root_idx)
  );

endmodule
